>>> sv/hff_pkg.sv
// hff_pkg: shared constants, command type and character helpers for the
// hex field formatter. No dependencies; every other file but hff_if imports it.
package hff_pkg;

  // Largest field width and precision taken from a request.
  localparam int MaxField = 62;
  // The field must fit in 64 characters, so limits never exceed 62.
  localparam int FieldCap = 62;
  localparam logic [5:0] FieldLim = 6'((MaxField > FieldCap) ? FieldCap : MaxField);

  // Command queue between front and back.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  // ASCII codes
  localparam logic [6:0] ChSpace = 7'h20;
  localparam logic [6:0] ChZero  = 7'h30;
  localparam logic [6:0] ChLowX  = 7'h78;
  localparam logic [6:0] ChUpX   = 7'h58;
  localparam logic [6:0] ChLowA  = 7'h61;
  localparam logic [6:0] ChUpA   = 7'h41;

  // Classified field: what the back end has to emit, run by run.
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  ndig;       // hex digits of value, 1..8
    logic [5:0]  zeros;      // precision zeros ahead of the digits
    logic [5:0]  pad;        // padding characters
    logic        lead_sp;    // padding goes in front as spaces
    logic        lead_zero;  // padding goes after the prefix as zeros
    logic        trail_sp;   // padding goes last as spaces
    logic        prefix;     // emit 0x / 0X
    logic        upper;      // uppercase digits and X
  } hff_cmd_t;

  // Map one nibble to its ASCII hex digit.
  function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [6:0] base;
    base = upper ? ChUpA : ChLowA;
    if (nib < 4'd10) begin
      hex_char = ChZero + {3'b000, nib};
    end else begin
      hex_char = base + {3'b000, nib} - 7'd10;
    end
  endfunction

endpackage

>>> sv/hff_if.sv
// hff_if: valid/ready channels of the hex field formatter, the request
// channel and the character channel. No package dependencies.
interface hff_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [5:0]  field_width;
  logic        has_precision;
  logic [5:0]  min_digits;
  logic        pad_zero;
  logic        left_justify;
  logic        alt_prefix;
  logic        upper_case;

  modport source (
    output valid, value, field_width, has_precision, min_digits,
           pad_zero, left_justify, alt_prefix, upper_case,
    input  ready
  );
  modport sink (
    input  valid, value, field_width, has_precision, min_digits,
           pad_zero, left_justify, alt_prefix, upper_case,
    output ready
  );
endinterface

interface hff_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

>>> sv/hff_front.sv
// hff_front: accepts a request word and classifies it into run lengths.
// Depends on hff_pkg and hff_in_if.
module hff_front (
  hff_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output hff_pkg::hff_cmd_t   cmd_o
);
  import hff_pkg::*;

  logic [5:0] width_c;
  logic [5:0] pdig_c;
  logic [3:0] ndig_c;
  logic       zero_c;
  logic       pre_c;
  logic [5:0] body_c;
  logic [6:0] used_c;

  // Take a word whenever the queue has room.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Count significant nibbles, at least one.
  always_comb begin
    ndig_c = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (in_i.value[4*i +: 4] != 4'd0) begin
        ndig_c = 4'(i + 1);
      end
    end
  end

  // Saturate width and precision, then size the body and padding.
  always_comb begin
    width_c = (in_i.field_width > FieldLim) ? FieldLim : in_i.field_width;
    pdig_c  = (in_i.min_digits > FieldLim) ? FieldLim : in_i.min_digits;
    zero_c  = in_i.pad_zero && !in_i.has_precision && !in_i.left_justify;
    pre_c   = in_i.alt_prefix && (in_i.value != 32'd0);
    body_c  = (in_i.has_precision && (pdig_c > {2'b00, ndig_c})) ? pdig_c
                                                                 : {2'b00, ndig_c};
    used_c  = {1'b0, body_c} + (pre_c ? 7'd2 : 7'd0);

    cmd_o.value     = in_i.value;
    cmd_o.ndig      = ndig_c;
    cmd_o.zeros     = body_c - {2'b00, ndig_c};
    cmd_o.pad       = ({1'b0, width_c} > used_c) ? 6'({1'b0, width_c} - used_c) : 6'd0;
    cmd_o.lead_sp   = !in_i.left_justify && !zero_c;
    cmd_o.lead_zero = zero_c;
    cmd_o.trail_sp  = in_i.left_justify;
    cmd_o.prefix    = pre_c;
    cmd_o.upper     = in_i.upper_case;
  end

endmodule

>>> sv/hff_queue.sv
// hff_queue: short FIFO of classified commands between front and back.
// Depends on hff_pkg.
module hff_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hff_pkg::hff_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              avail_o,
  output hff_pkg::hff_cmd_t head_o
);
  import hff_pkg::*;

  hff_cmd_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (QPtrW+1)'(QueueDepth));
  assign avail_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPtrW+1)'(QueueDepth)) else $error("queue occupancy out of range");

endmodule

>>> sv/hff_back.sv
// hff_back: run sequencer; emits one character per cycle, unless stalled, from a
// queued command into a registered output stage. Depends on hff_pkg, hff_out_if.
module hff_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  hff_pkg::hff_cmd_t head_i,
  output logic              pop_o,
  hff_out_if.source         out_o
);
  import hff_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LEAD  = 8'b0000_0010,
    ST_PFX0  = 8'b0000_0100,
    ST_PFXX  = 8'b0000_1000,
    ST_ZPAD  = 8'b0001_0000,
    ST_PZERO = 8'b0010_0000,
    ST_DIGIT = 8'b0100_0000,
    ST_TRAIL = 8'b1000_0000
  } phase_e;

  phase_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  hff_cmd_t   cmd_q;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  logic       adv;
  logic       emit;
  logic       load;
  phase_e     first_ph;
  phase_e     next_ph;
  logic [2:0] dig_idx;
  logic [3:0] nib;

  // Runs that are not empty for a command, one bit per phase.
  function automatic logic [7:0] run_mask(input hff_cmd_t c);
    logic pad_nz;
    pad_nz   = (c.pad != 6'd0);
    run_mask = {c.trail_sp && pad_nz, 1'b1, c.zeros != 6'd0, c.lead_zero && pad_nz,
                c.prefix, c.prefix, c.lead_sp && pad_nz, 1'b0};
  endfunction

  // Lowest non-empty run after the current one, or idle.
  function automatic phase_e next_run(input logic [7:0] mask, input phase_e cur);
    logic [7:0] above;
    logic [7:0] low;
    above = mask & ~(cur | (cur - 8'd1));
    low   = above & (~above + 8'd1);
    next_run = (above == 8'd0) ? ST_IDLE : phase_e'(low);
  endfunction

  // Characters in one run.
  function automatic logic [5:0] run_len(input hff_cmd_t c, input phase_e ph);
    unique case (ph) inside
      ST_LEAD, ST_ZPAD, ST_TRAIL: run_len = c.pad;
      ST_PFX0, ST_PFXX:           run_len = 6'd1;
      ST_PZERO:                   run_len = c.zeros;
      ST_DIGIT:                   run_len = {2'b00, c.ndig};
      default:                    run_len = 6'd0;
    endcase
  endfunction

  assign adv      = !out_valid_q || out_o.ready;
  assign load     = (state_q == ST_IDLE) && avail_i;
  assign emit     = (state_q != ST_IDLE) && adv;
  assign pop_o    = load;
  assign first_ph = next_run(run_mask(head_i), ST_IDLE);
  assign next_ph  = next_run(run_mask(cmd_q), state_q);
  assign dig_idx  = cnt_q[2:0] - 3'd1;
  assign nib      = 4'(cmd_q.value >> {dig_idx, 2'b00});

  // Step through the runs of the current command.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (load) begin
      state_d = first_ph;
      cnt_d   = run_len(head_i, first_ph);
    end else if (emit) begin
      if (cnt_q == 6'd1) begin
        state_d = next_ph;
        cnt_d   = run_len(cmd_q, next_ph);
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  // Pick the character of the current run.
  always_comb begin
    unique case (state_q) inside
      ST_LEAD, ST_TRAIL: out_char_d = ChSpace;
      ST_PFX0, ST_ZPAD, ST_PZERO: out_char_d = ChZero;
      ST_PFXX:  out_char_d = cmd_q.upper ? ChUpX : ChLowX;
      ST_DIGIT: out_char_d = hex_char(nib, cmd_q.upper);
      default:  out_char_d = ChSpace;
    endcase
    out_last_d  = (cnt_q == 6'd1) && (next_ph == ST_IDLE);
    out_valid_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold command and output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= head_i;
    end
    if (emit) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> cnt_q != 6'd0) else $error("empty run entered");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_last_d |=> state_q == ST_IDLE) else $error("last without field end");
  a_end_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && state_d == ST_IDLE |=> out_o.last) else $error("field end without last");

endmodule

>>> sv/hex_field_formatter.sv
// hex_field_formatter: printf-style %x field formatter, top level.
// Depends on hff_pkg, hff_if, hff_front, hff_queue and hff_back.
//
// Each request word carries a 32-bit value and its field options; the block
// answers with the formatted field, one ASCII character per word, last set on
// the final one. On the output side the back-end sequencer first loads the
// next command from the queue while idle, then emits one character per cycle
// through its output register while the output is not stalled. A field has
// N characters, N being the larger of the saturated field width and prefix
// plus digits (precision included), so 1 to 64 characters per request. The
// front end classifies a request in the cycle it is taken and parks it in a
// four-entry command queue, so up to four requests are accepted while a
// field is still being emitted.
module hex_field_formatter (
  input  logic       clk_i,
  input  logic       rst_ni,
  hff_in_if.sink     in_i,
  hff_out_if.source  out_o
);
  import hff_pkg::*;

  logic     push;
  logic     full;
  logic     pop;
  logic     avail;
  hff_cmd_t cmd;
  hff_cmd_t head;

  hff_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  hff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .head_o  (head)
  );

  hff_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
